@@ hdl/dtsit_pkg.sv @@
// ----------------------------------------------------------------------------
// dtsit_pkg
// Shared types and constants of the debounced two-stage idle timer.
// ----------------------------------------------------------------------------
`default_nettype none
package dtsit_pkg;
	localparam logic [1:0] OP_POLL  = 2'd0;
	localparam logic [1:0] OP_FORCE = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] MODE_AWAKE    = 2'd0;
	localparam logic [1:0] MODE_PRESLEEP = 2'd1;
	localparam logic [1:0] MODE_SLEEP    = 2'd2;

	localparam int unsigned MIN_W  = 11;
	localparam int unsigned REM_W  = 18;
	localparam logic [31:0] MS_PER_MIN = 32'd60000;

	localparam logic [1:0] REG_PRE_CH0 = 2'd0;
	localparam logic [1:0] REG_SLP_CH0 = 2'd1;
	localparam logic [1:0] REG_PRE_CH1 = 2'd2;
	localparam logic [1:0] REG_SLP_CH1 = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic        channel;
		logic        raw_idle;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [REM_W-1:0] remaining_seconds;
		logic             idle_level;
	} out_word_t;

	// front-to-back queue entry: resolved state after the step
	typedef struct packed {
		logic        valid_ch;
		logic [1:0]  mode;
		logic        idle_level;
		logic        running;
		logic [31:0] elapsed;
		logic [31:0] target;
		logic        has_target;
	} job_t;
endpackage
`default_nettype wire

@@ hdl/dtsit_if.sv @@
// ----------------------------------------------------------------------------
// dtsit_in_if / dtsit_out_if
// Valid/ready channels carrying one input or result word.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtsit_in_if;
	logic                valid;
	logic                ready;
	dtsit_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dtsit_out_if;
	logic                 valid;
	logic                 ready;
	dtsit_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/debounced_two_stage_idle_timer.sv @@
// ----------------------------------------------------------------------------
// debounced_two_stage_idle_timer
// Per-channel debounced idle detection with presleep and sleep timeouts.
// ----------------------------------------------------------------------------
// Usage: words enter on in (operation, channel, raw_idle, now_ms); each
// word gives exactly one result word on out (mode, remaining_seconds,
// idle_level). Timeouts are set through the write port (cfg_we, cfg_index,
// cfg_data), register order presleep ch0, sleep ch0, presleep ch1, sleep ch1,
// in minutes, zero disables a stage; write only while the block is idle.
// The front end updates channel state in the accept cycle and pushes the
// resolved job into a two-entry queue; the back end turns it into rounded
// seconds and loads the output register. An accepted word passes the queue
// and then the output register before its result is valid; one word per
// cycle is sustained while out is taken.
// When the receiver stalls the output register holds, the queue fills and
// in.ready drops once it holds two jobs.
// Reset clears channel state, configuration and control registers to zero
// (awake, not idle), with no clearing pass; queue and output data are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module debounced_two_stage_idle_timer #(
	parameter int unsigned DEBOUNCE_POLLS = 5,
	parameter int unsigned NUM_CHANNELS   = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	dtsit_in_if.sink         in,
	dtsit_out_if.source      out
);
	logic [dtsit_pkg::MIN_W-1:0] pre_q [2];
	logic [dtsit_pkg::MIN_W-1:0] slp_q [2];
	logic            fire;
	logic            space;
	dtsit_pkg::job_t job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q[0] <= '0;
			pre_q[1] <= '0;
			slp_q[0] <= '0;
			slp_q[1] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dtsit_pkg::REG_PRE_CH0: pre_q[0] <= cfg_data;
				dtsit_pkg::REG_SLP_CH0: slp_q[0] <= cfg_data;
				dtsit_pkg::REG_PRE_CH1: pre_q[1] <= cfg_data;
				dtsit_pkg::REG_SLP_CH1: slp_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in.ready = space;
	assign fire     = in.valid && space;

	dtsit_front #(
		.DEBOUNCE_POLLS(DEBOUNCE_POLLS),
		.NUM_CHANNELS  (NUM_CHANNELS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (in.data),
		.pre_min(pre_q),
		.slp_min(slp_q),
		.job    (job)
	);

	dtsit_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.job   (job),
		.space (space),
		.out   (out)
	);
endmodule
`default_nettype wire

@@ hdl/dtsit_front.sv @@
// ----------------------------------------------------------------------------
// dtsit_front
// Accepts words, updates the per-channel debounce and timer state, and
// resolves the mode plus the deadline that the back end turns into seconds.
// ----------------------------------------------------------------------------
`default_nettype none
module dtsit_front #(
	parameter int unsigned DEBOUNCE_POLLS = 5,
	parameter int unsigned NUM_CHANNELS   = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire dtsit_pkg::in_word_t   word,
	input  wire logic [dtsit_pkg::MIN_W-1:0] pre_min [2],
	input  wire logic [dtsit_pkg::MIN_W-1:0] slp_min [2],
	output dtsit_pkg::job_t            job
);
	logic [1:0]  mode_q      [2];
	logic        stable_q    [2];
	logic        cand_q      [2];
	logic [7:0]  polls_q     [2];
	logic [31:0] start_q     [2];

	logic        ch;
	logic        ch_ok;
	logic        raw;
	logic [31:0] now;
	logic [31:0] stamp;
	logic        n_cand;
	logic [7:0]  n_polls;
	logic        deb;
	logic        n_stable;
	logic [31:0] n_start;
	logic [1:0]  n_mode;
	logic [31:0] elapsed;
	logic [31:0] pre_ms;
	logic [31:0] slp_ms;
	logic [31:0] pre;
	logic [31:0] slp;

	assign ch    = word.channel;
	assign ch_ok = (32'(ch) < NUM_CHANNELS);
	assign raw   = word.raw_idle;
	assign now   = word.now_ms;
	assign stamp = (now == 32'd0) ? 32'd1 : now;
	assign pre   = 32'(pre_min[ch]);
	assign slp   = 32'(slp_min[ch]);
	assign pre_ms = pre * dtsit_pkg::MS_PER_MIN;
	assign slp_ms = slp * dtsit_pkg::MS_PER_MIN;

	// next state of the addressed channel
	always_comb begin
		n_cand   = cand_q[ch];
		n_polls  = polls_q[ch];
		n_stable = stable_q[ch];
		n_start  = start_q[ch];
		n_mode   = mode_q[ch];
		deb      = stable_q[ch];
		elapsed  = 32'd0;
		if (word.operation == dtsit_pkg::OP_POLL) begin
			if (raw == cand_q[ch]) begin
				if (polls_q[ch] < 8'(DEBOUNCE_POLLS))
					n_polls = polls_q[ch] + 8'd1;
			end else begin
				n_cand  = raw;
				n_polls = 8'd1;
			end
			deb = (n_polls >= 8'(DEBOUNCE_POLLS)) ? n_cand : stable_q[ch];
			if (deb && !stable_q[ch]) begin
				n_start = stamp;
				n_mode  = dtsit_pkg::MODE_AWAKE;
			end else if (!deb && stable_q[ch]) begin
				n_start = 32'd0;
				n_mode  = dtsit_pkg::MODE_AWAKE;
			end
			n_stable = deb;
			elapsed  = now - n_start;
			if (deb && n_start != 32'd0) begin
				if (pre != 32'd0) begin
					if (elapsed < pre_ms)
						n_mode = dtsit_pkg::MODE_AWAKE;
					else if (slp != 32'd0)
						n_mode = ((elapsed - pre_ms) >= slp_ms) ?
							dtsit_pkg::MODE_SLEEP : dtsit_pkg::MODE_PRESLEEP;
					else
						n_mode = dtsit_pkg::MODE_PRESLEEP;
				end else if (slp != 32'd0) begin
					n_mode = (elapsed >= slp_ms) ?
						dtsit_pkg::MODE_SLEEP : dtsit_pkg::MODE_AWAKE;
				end else begin
					n_mode = dtsit_pkg::MODE_AWAKE;
				end
			end
		end else if (word.operation == dtsit_pkg::OP_FORCE) begin
			n_mode  = dtsit_pkg::MODE_AWAKE;
			n_start = stable_q[ch] ? stamp : 32'd0;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				mode_q[i]   <= dtsit_pkg::MODE_AWAKE;
				stable_q[i] <= 1'b0;
				cand_q[i]   <= 1'b0;
				polls_q[i]  <= 8'd0;
				start_q[i]  <= 32'd0;
			end
		end else if (fire && ch_ok) begin
			mode_q[ch]   <= n_mode;
			stable_q[ch] <= n_stable;
			cand_q[ch]   <= n_cand;
			polls_q[ch]  <= n_polls;
			start_q[ch]  <= n_start;
		end
	end

	// deadline for the remaining-time computation
	always_comb begin
		job.valid_ch   = ch_ok;
		job.mode       = n_mode;
		job.idle_level = n_stable;
		job.running    = (n_start != 32'd0);
		job.elapsed    = now - n_start;
		job.target     = 32'd0;
		job.has_target = 1'b0;
		unique case (n_mode)
			dtsit_pkg::MODE_AWAKE: begin
				if (pre != 32'd0) begin
					job.target = pre_ms;
					job.has_target = 1'b1;
				end else if (slp != 32'd0) begin
					job.target = slp_ms;
					job.has_target = 1'b1;
				end
			end
			dtsit_pkg::MODE_PRESLEEP: begin
				if (slp != 32'd0) begin
					job.target = pre_ms + slp_ms;
					job.has_target = 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/dtsit_back.sv @@
// ----------------------------------------------------------------------------
// dtsit_back
// Two-entry queue of resolved jobs, then the ceil-by-1000 stage with an
// output register toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module dtsit_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dtsit_pkg::job_t job,
	output logic                 space,
	dtsit_out_if.source          out
);
	dtsit_pkg::job_t fifo_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            pop;
	dtsit_pkg::job_t head;
	logic [31:0]     diff;
	logic [49:0]     prod;
	logic [31:0]     quo;
	logic [31:0]     num;
	logic [dtsit_pkg::REM_W-1:0] secs;

	// queue
	assign head  = fifo_q[rd_q];
	assign pop   = (cnt_q != 2'd0) && (!out.valid || out.ready);
	assign space = (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= job;
	end

	// ceil(diff/1000): reciprocal multiply on the shifted value, then fix up
	always_comb begin
		diff = head.target - head.elapsed;
		num  = diff + 32'd999;
		// num < 2^28 so num>>3 fits 25 bits; 1/125 ~ 268435/2^25, estimate low by at most one
		prod = 50'(num >> 3) * 50'd268435;
		quo  = 32'(prod >> 25);
		if (32'(quo + 32'd1) * 32'd1000 <= num) quo = quo + 32'd1;
		if (!head.valid_ch || !head.running || !head.has_target ||
			head.elapsed >= head.target)
			secs = '0;
		else
			secs = quo[dtsit_pkg::REM_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out.valid <= 1'b0;
		end else if (pop) begin
			out.valid <= 1'b1;
		end else if (out.ready) begin
			out.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out.data.mode              <= head.valid_ch ? head.mode : dtsit_pkg::MODE_AWAKE;
			out.data.remaining_seconds <= secs;
			out.data.idle_level        <= head.valid_ch & head.idle_level;
		end
	end
endmodule
`default_nettype wire

@@ hdl/dtsit_checker.sv @@
// ----------------------------------------------------------------------------
// dtsit_checker
// Port-level checks of the idle timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dtsit_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_mode,
	input wire logic [17:0] out_rem,
	input wire logic        out_idle
);
	// a result cannot appear without an earlier accept
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid))
		else $error("result without accepted word");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_rem))
		else $error("stalled result changed");
	// sleep never reports time left
	a_sleep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mode == 2'd2 |-> out_rem == 18'd0)
		else $error("sleep with time left");
	// a non-awake mode needs a debounced idle level
	a_mode_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mode != 2'd0 |-> out_idle)
		else $error("mode without idle");
endmodule

bind debounced_two_stage_idle_timer dtsit_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in.valid),
	.in_ready (in.ready),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.out_mode (out.data.mode),
	.out_rem  (out.data.remaining_seconds),
	.out_idle (out.data.idle_level)
);
`default_nettype wire
